>>> rtl/core/mrp_pkg.sv
// Package with shared constants and types for the Modbus read response parser.
`default_nettype none

package mrp_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MRP_STORE_BYTES = 100;
   localparam int MRP_METER_SLOTS = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;

   // Parse step codes.
   localparam logic [2:0] STEP_ID    = 3'd0;
   localparam logic [2:0] STEP_FUNC  = 3'd1;
   localparam logic [2:0] STEP_COUNT = 3'd2;
   localparam logic [2:0] STEP_DATA  = 3'd3;
   localparam logic [2:0] STEP_END   = 3'd4;

   // Result kind codes.
   localparam logic [1:0] KIND_COUNT = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_METER_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_WORDS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_SLOT     = 2'd2;

   typedef struct packed {
      logic [4:0] meter_count;
      logic [6:0] expected_words;
      logic [3:0] frame_slot;
   } mrp_cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] meter_id;
      logic [3:0] frame_number;
      logic [6:0] byte_index;
      logic [7:0] value;
   } mrp_result_type;

endpackage

`default_nettype wire

>>> rtl/core/mrp_channels_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
`default_nettype none

interface mrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] meter_id;
   logic [3:0] frame_number;
   logic [6:0] byte_index;
   logic [7:0] value;

   modport source (output valid, output kind, output meter_id, output frame_number,
                   output byte_index, output value, input ready);
   modport sink   (input valid, input kind, input meter_id, input frame_number,
                   input byte_index, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mrp_step.sv
// Parse state registers and the per-byte step logic of the response parser.
`default_nettype none

module mrp_step #(
   parameter int STORE_BYTES = mrp_pkg::MRP_STORE_BYTES,
   parameter int METER_SLOTS = mrp_pkg::MRP_METER_SLOTS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              rx_byte,
   input  wire mrp_pkg::mrp_cfg_type    cfg,
   output logic                         push,
   output mrp_pkg::mrp_result_type      result
);
   import mrp_pkg::*;

   logic [2:0] step_ff, step_in;
   logic [4:0] meter_ff, meter_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] left_dec;
   logic       id_ok;

   assign left_dec = left_ff - 8'd1;
   assign id_ok = (rx_byte != 8'd0) && (rx_byte <= {3'd0, cfg.meter_count})
                  && (rx_byte <= 8'(METER_SLOTS));

   always_comb begin
      step_in = step_ff;
      meter_in = meter_ff;
      left_in = left_ff;
      pos_in = pos_ff;
      push = 1'b0;
      result.kind = KIND_END;
      result.meter_id = meter_ff;
      result.frame_number = cfg.frame_slot;
      result.byte_index = 7'd0;
      result.value = 8'd0;
      if (accept) begin
         case (step_ff)
            STEP_FUNC: begin
               step_in = (rx_byte == FUNC_READ_HOLDING) ? STEP_COUNT : STEP_ID;
            end
            STEP_COUNT: begin
               pos_in = 8'd0;
               if (rx_byte == {cfg.expected_words, 1'b0}) begin
                  left_in = rx_byte;
                  step_in = (rx_byte == 8'd0) ? STEP_END : STEP_DATA;
                  push = 1'b1;
                  result.kind = KIND_COUNT;
                  result.value = rx_byte;
               end else begin
                  step_in = STEP_ID;
               end
            end
            STEP_DATA: begin
               // Bytes past the store are still counted so the frame end lands right.
               if (pos_ff < 8'(STORE_BYTES)) begin
                  push = 1'b1;
                  result.kind = KIND_DATA;
                  result.byte_index = pos_ff[6:0];
                  result.value = rx_byte;
               end
               pos_in = pos_ff + 8'd1;
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  step_in = STEP_END;
               end
            end
            STEP_END: begin
               step_in = STEP_ID;
               push = 1'b1;
               result.kind = KIND_END;
            end
            default: begin
               step_in = STEP_ID;
               if (id_ok) begin
                  meter_in = rx_byte[4:0];
                  step_in = STEP_FUNC;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_ID;
         meter_ff <= 5'd0;
         left_ff <= 8'd0;
         pos_ff <= 8'd0;
      end else begin
         step_ff <= step_in;
         meter_ff <= meter_in;
         left_ff <= left_in;
         pos_ff <= pos_in;
      end
   end

   a_end_returns_to_id: assert property (@(posedge clock) disable iff (reset)
      (accept && step_ff == STEP_END) |=> (step_ff == STEP_ID))
      else $error("frame end did not return to slave id step");

   a_data_needs_bytes_left: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_DATA) |-> (left_ff != 8'd0))
      else $error("data step entered with no bytes left");

   a_step_code_known: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_END)
      else $error("parse step holds an unused code");

endmodule

`default_nettype wire

>>> rtl/core/mrp_rsp_queue.sv
// Two-entry result queue that lets a new byte in while a result waits.
`default_nettype none

module mrp_rsp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire mrp_pkg::mrp_result_type push_data,
   output logic                         space,
   output logic                         out_valid,
   output mrp_pkg::mrp_result_type      out_data,
   input  wire logic                    out_ready
);
   import mrp_pkg::*;

   mrp_result_type entry_ff [2];
   logic           wr_ff, wr_in;
   logic           rd_ff, rd_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign space = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = entry_ff[rd_ff];
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("item pushed into a full result queue");

   a_count_tracks_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ff != rd_ff))
      else $error("queue count disagrees with pointers");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count above its depth");

endmodule

`default_nettype wire

>>> rtl/core/modbus_read_response_parser_core.sv
// Top level of the Modbus read-holding-registers response parser.
// Takes one received byte per cycle and reports the byte count, each data byte inside the
// store with its index, and the frame end (on the byte after the data, normally the first
// CRC byte). Bytes pass the combinational step logic; the result then sits in a two-entry
// queue, so a byte is accepted every cycle as long as the result side keeps up, and the
// input stalls only when both queue entries wait. No CRC check is made. Configuration
// registers are written through the csr_ port and must only change while the block idles.
`default_nettype none

module modbus_read_response_parser_core #(
   parameter int STORE_BYTES = mrp_pkg::MRP_STORE_BYTES,
   parameter int METER_SLOTS = mrp_pkg::MRP_METER_SLOTS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mrp_req_if.sink                               req,
   mrp_rsp_if.source                             rsp,
   input  wire logic                             csr_we,
   input  wire logic [mrp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mrp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mrp_pkg::*;

   mrp_cfg_type    cfg_ff;
   mrp_result_type step_result;
   mrp_result_type out_data;
   logic           step_push;
   logic           space;
   logic           accept;

   assign req.ready = space;
   assign accept = req.valid && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.meter_count <= 5'd16;
         cfg_ff.expected_words <= 7'd1;
         cfg_ff.frame_slot <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_METER_COUNT:    cfg_ff.meter_count <= csr_wdata[4:0];
            CSR_EXPECTED_WORDS: cfg_ff.expected_words <= csr_wdata;
            CSR_FRAME_SLOT:     cfg_ff.frame_slot <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   mrp_step #(
      .STORE_BYTES (STORE_BYTES),
      .METER_SLOTS (METER_SLOTS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req.rx_byte),
      .cfg     (cfg_ff),
      .push    (step_push),
      .result  (step_result)
   );

   mrp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (step_result),
      .space     (space),
      .out_valid (rsp.valid),
      .out_data  (out_data),
      .out_ready (rsp.ready)
   );

   assign rsp.kind = out_data.kind;
   assign rsp.meter_id = out_data.meter_id;
   assign rsp.frame_number = out_data.frame_number;
   assign rsp.byte_index = out_data.byte_index;
   assign rsp.value = out_data.value;

endmodule

`default_nettype wire

>>> tb/mrp_report_checker.sv
// Checker that predicts the parser's results from the accepted bytes and compares them.
`timescale 1ns / 100ps

module mrp_report_checker #(
   parameter int STORE_BYTES = mrp_pkg::MRP_STORE_BYTES,
   parameter int METER_SLOTS = mrp_pkg::MRP_METER_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   mrp_req_if                              req_mon,
   mrp_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [mrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              awaited_count
);
   import mrp_pkg::*;

   logic [4:0] meters_cfg;
   logic [6:0] words_cfg;
   logic [3:0] slot_cfg;
   logic [2:0] parse_at;
   logic [4:0] meter;
   logic [7:0] bytes_left;
   logic [7:0] data_pos;
   int         errors;

   mrp_result_type awaited_reports[$];

   task automatic add_report(input logic [1:0] kind, input logic [6:0] idx,
                             input logic [7:0] val);
      mrp_result_type r;
      r.kind         = kind;
      r.meter_id     = meter;
      r.frame_number = slot_cfg;
      r.byte_index   = idx;
      r.value        = val;
      awaited_reports.push_back(r);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : track
      mrp_result_type want;
      logic [7:0]     b;
      if (reset) begin
         meters_cfg = 5'd16;
         words_cfg  = 7'd1;
         slot_cfg   = 4'd1;
         parse_at   = STEP_ID;
         meter      = '0;
         bytes_left = '0;
         data_pos   = '0;
         errors     = 0;
         awaited_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_METER_COUNT:    meters_cfg = csr_wdata[4:0];
               CSR_EXPECTED_WORDS: words_cfg  = csr_wdata[6:0];
               CSR_FRAME_SLOT:     slot_cfg   = csr_wdata[3:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            b = req_mon.rx_byte;
            case (parse_at)
               STEP_FUNC: begin
                  parse_at = (b == FUNC_READ_HOLDING) ? STEP_COUNT : STEP_ID;
               end
               STEP_COUNT: begin
                  data_pos = '0;
                  // The count byte must be exactly twice the word count.
                  if (b == {words_cfg, 1'b0}) begin
                     bytes_left = b;
                     parse_at   = (b == 8'd0) ? STEP_END : STEP_DATA;
                     add_report(KIND_COUNT, 7'd0, b);
                  end else begin
                     parse_at = STEP_ID;
                  end
               end
               STEP_DATA: begin
                  // Bytes past the store are still counted, just not reported.
                  if (data_pos < STORE_BYTES) add_report(KIND_DATA, data_pos[6:0], b);
                  data_pos   = data_pos + 8'd1;
                  bytes_left = bytes_left - 8'd1;
                  if (bytes_left == 8'd0) parse_at = STEP_END;
               end
               STEP_END: begin
                  parse_at = STEP_ID;
                  add_report(KIND_END, 7'd0, 8'd0);
               end
               default: begin
                  parse_at = STEP_ID;
                  if (b >= 8'd1 && b <= meters_cfg && b <= METER_SLOTS) begin
                     meter    = b[4:0];
                     parse_at = STEP_FUNC;
                  end
               end
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_reports.size() == 0) begin
               $error("result with nothing awaited: kind %0d, meter_id %0d, value %0d",
                      rsp_mon.kind, rsp_mon.meter_id, rsp_mon.value);
               errors++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("kind", want.kind, rsp_mon.kind);
               check_field("meter_id", want.meter_id, rsp_mon.meter_id);
               check_field("frame_number", want.frame_number, rsp_mon.frame_number);
               check_field("byte_index", want.byte_index, rsp_mon.byte_index);
               check_field("value", want.value, rsp_mon.value);
            end
         end
      end
      awaited_count  <= awaited_reports.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/modbus_read_response_parser_core_test.sv
// Testbench top for the Modbus read response parser: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module modbus_read_response_parser_core_test;
   import mrp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 6;
   localparam int RANDOM_PHASES   = 7;
   localparam int BYTES_PER_PHASE = 100;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     report_errors;
   int                     reports_awaited;
   int                     bytes_sent;
   int                     cur_meters;
   int                     cur_words;
   bit                     steady_sender;

   mrp_req_if req_ch ();
   mrp_rsp_if rsp_ch ();

   modbus_read_response_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mrp_report_checker report_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (report_errors),
      .awaited_count  (reports_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: mostly ready, short and occasional long stalls, and stretches of no stall.
   initial begin : rsp_pacing
      int stall_left;
      int steady_left;
      stall_left  = 0;
      steady_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady_left > 0) begin
            steady_left--;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: stall_left = $urandom_range(1, 3);
               5:             stall_left = $urandom_range(10, 30);
               6:             steady_left = $urandom_range(50, 200);
               default: ;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!steady_sender) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            6:                gap = $urandom_range(8, 30);
            default:          gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   // Stops sending and waits until every awaited result is in and the step logic is quiet.
   task automatic hold_sender();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (reports_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_METER_COUNT) cur_meters = data[4:0];
      else if (idx == CSR_EXPECTED_WORDS) cur_words = data;
   endtask

   initial begin : stimulus
      int         phase_end;
      int         id_top;
      int         n;
      logic [7:0] b;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'd0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_METER_COUNT;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      bytes_sent    = 0;
      cur_meters    = 16;
      cur_words     = 1;
      steady_sender = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: id zero, a wrong function code, a wrong byte count, then a frame.
      send_byte(8'd0);  send_byte(8'd5);  send_byte(8'd4);
      send_byte(8'd16); send_byte(FUNC_READ_HOLDING); send_byte(8'd7);
      send_byte(8'd1);  send_byte(FUNC_READ_HOLDING); send_byte(8'd2);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'hAA);
      hold_sender();

      // Ids above the slots are rejected even with a larger meter count; zero words.
      write_reg(CSR_METER_COUNT, 7'd31);
      write_reg(CSR_EXPECTED_WORDS, 7'd0);
      write_reg(CSR_FRAME_SLOT, 7'd0);
      send_byte(8'd17); send_byte(8'd31); send_byte(8'd16);
      send_byte(FUNC_READ_HOLDING); send_byte(8'd0); send_byte(8'h55);
      hold_sender();

      // Single meter, and a word count changed while the parser sits after the id.
      write_reg(CSR_METER_COUNT, 7'd1);
      write_reg(CSR_FRAME_SLOT, 7'd15);
      send_byte(8'd2); send_byte(8'd1);
      hold_sender();
      write_reg(CSR_EXPECTED_WORDS, 7'd2);
      write_reg(CSR_UNUSED, 7'h7F);
      send_byte(FUNC_READ_HOLDING); send_byte(8'd4);
      send_byte(8'h80); send_byte(8'h7F); send_byte(8'h01); send_byte(8'hFE);
      send_byte(8'h33);
      hold_sender();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 7) == 0) write_reg(CSR_METER_COUNT, 7'($urandom_range(0, 127)));
         else write_reg(CSR_METER_COUNT, 7'($urandom_range(1, 16)));
         // Phases 2 and 4 run frames past the store; the rest mostly keep frames short.
         if (phase == 2) n = 51;
         else if (phase == 4) n = 127;
         else if ($urandom_range(0, 5) == 0) n = $urandom_range(9, 60);
         else n = $urandom_range(1, 8);
         write_reg(CSR_EXPECTED_WORDS, 7'(n));
         write_reg(CSR_FRAME_SLOT, 7'($urandom_range(0, 127)));

         phase_end = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < phase_end) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            if (cur_meters == 0) id_top = 1;
            else if (cur_meters > MRP_METER_SLOTS) id_top = MRP_METER_SLOTS;
            else id_top = cur_meters;
            n = 2 * cur_words;
            case ($urandom_range(0, 9))
               0: send_byte(8'($urandom_range(0, 255)));
               1: begin
                  b = 8'($urandom_range(0, 255));
                  if (b == FUNC_READ_HOLDING) b = 8'd0;
                  send_byte(8'($urandom_range(1, id_top)));
                  send_byte(b);
               end
               2: begin
                  send_byte(8'($urandom_range(1, id_top)));
                  send_byte(FUNC_READ_HOLDING);
                  if ($urandom_range(0, 1) == 0) begin
                     b = 8'($urandom_range(0, 255));
                     if (b == 8'(n)) b = b ^ 8'd1;
                     send_byte(b);
                  end else begin
                     // Frame cut short: the next frame's bytes land in the data.
                     send_byte(8'(n));
                     repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom_range(0, 255)));
                  end
               end
               3: begin
                  if ($urandom_range(0, 1) == 0) send_byte(8'd0);
                  else send_byte(8'($urandom_range(id_top + 1, 255)));
               end
               default: begin
                  send_byte(8'($urandom_range(1, id_top)));
                  send_byte(FUNC_READ_HOLDING);
                  send_byte(8'(n));
                  repeat (n) send_byte(8'($urandom_range(0, 255)));
                  send_byte(8'($urandom_range(0, 255)));
               end
            endcase
         end
         steady_sender = 1'b0;
         hold_sender();
      end

      if (report_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mrp_pkg.sv
rtl/core/mrp_channels_if.sv
rtl/core/mrp_step.sv
rtl/core/mrp_rsp_queue.sv
rtl/core/modbus_read_response_parser_core.sv
tb/mrp_report_checker.sv
tb/modbus_read_response_parser_core_test.sv
